/* sv/kwp2000_header_framer_assert.svh */
// Assertion macros shared by the framer checkers.
// Each macro expects aclk and aresetn to be visible where it is used.
`ifndef KWP2000_HEADER_FRAMER_ASSERT_SVH
`define KWP2000_HEADER_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define KWP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// Next-cycle implication, disabled while reset is held.
`define KWP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

/* sv/kwp_pkg.sv */
// ----------------------------------------------------------------------------
// kwp_pkg
// Types and constants of the KWP2000 request header framer.
// ----------------------------------------------------------------------------
`default_nettype none

package kwp_pkg;

    // Most frame bytes a single request can produce
    localparam int MAX_RESULTS = 6;
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // Header rule constants
    localparam logic [7:0] SID_START_COMM = 8'h81;
    localparam int         KEY_ADDR_BIT   = 3;
    localparam int         KEY_LEN_BIT    = 0;
    localparam logic [7:0] MAX_LEN_IN_FMT = 8'd62;
    localparam logic [5:0] FMT_LEN_MASK   = 6'h3F;

    // Register indexes on the configuration port
    localparam logic [7:0] CFG_IDX_FORMAT_BASE    = 8'd0;
    localparam logic [7:0] CFG_IDX_TARGET_ADDRESS = 8'd1;
    localparam logic [7:0] CFG_IDX_SOURCE_ADDRESS = 8'd2;
    localparam logic [7:0] CFG_IDX_KEY_BYTE_TWO   = 8'd3;

    // Register reset values
    localparam logic [7:0] RST_FORMAT_BASE    = 8'h80;
    localparam logic [7:0] RST_TARGET_ADDRESS = 8'h00;
    localparam logic [7:0] RST_SOURCE_ADDRESS = 8'hF1;
    localparam logic [7:0] RST_KEY_BYTE_TWO   = 8'h00;

    typedef struct packed {
        logic [7:0] sid;
        logic [7:0] payload_length;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic [7:0] format_base;
        logic [7:0] target_address;
        logic [7:0] source_address;
        logic [7:0] key_byte_two;
    } cfg_t;

    // Frame bytes one request expands into
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [IDX_W-1:0]            last_idx;
        logic                        last_end;
    } plan_t;

endpackage

`default_nettype wire

/* sv/kwp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// kwp_cfg_regs
// Configuration register file: format base, addresses and key byte two.
// ----------------------------------------------------------------------------
`default_nettype none

module kwp_cfg_regs
    import kwp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output cfg_t            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode the register index; drop writes to unknown indexes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_IDX_FORMAT_BASE:    cfg_next.format_base    = cfg_data;
                CFG_IDX_TARGET_ADDRESS: cfg_next.target_address = cfg_data;
                CFG_IDX_SOURCE_ADDRESS: cfg_next.source_address = cfg_data;
                CFG_IDX_KEY_BYTE_TWO:   cfg_next.key_byte_two   = cfg_data;
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.format_base    <= RST_FORMAT_BASE;
            cfg_reg.target_address <= RST_TARGET_ADDRESS;
            cfg_reg.source_address <= RST_SOURCE_ADDRESS;
            cfg_reg.key_byte_two   <= RST_KEY_BYTE_TWO;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* sv/kwp_hdr_plan.sv */
// ----------------------------------------------------------------------------
// kwp_hdr_plan
// Expands one request into its list of frame bytes and the next byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module kwp_hdr_plan
    import kwp_pkg::*;
(
    input  wire in_item_t   in_item,
    input  wire cfg_t       cfg,
    input  wire logic [7:0] rem,
    output plan_t           plan,
    output logic [7:0]      rem_next
);

    logic             start_comm;
    logic             addr;
    logic             len_byte;
    logic [7:0]       len;
    logic [7:0]       fmt;
    logic [IDX_W-1:0] pos;

    // Header decisions for the first request of a message
    assign start_comm = (in_item.sid == SID_START_COMM);
    assign addr       = start_comm || cfg.key_byte_two[KEY_ADDR_BIT];
    assign len_byte   = !start_comm &&
                        (!cfg.key_byte_two[KEY_LEN_BIT] ||
                         (in_item.payload_length > MAX_LEN_IN_FMT));
    assign len        = in_item.payload_length + 8'd1;
    assign fmt        = len_byte ? cfg.format_base
                                 : (cfg.format_base | {2'b00, len[5:0] & FMT_LEN_MASK});

    // Lay out the bytes in frame order
    always_comb begin
        plan     = '0;
        pos      = '0;
        rem_next = 8'd0;
        if (rem != 8'd0) begin
            // Message open: pass the data byte through
            plan.bytes[0] = in_item.data_byte;
            plan.last_idx = '0;
            plan.last_end = (rem == 8'd1);
            rem_next      = rem - 8'd1;
        end else begin
            plan.bytes[0] = fmt;
            pos           = IDX_W'(1);
            if (addr) begin
                plan.bytes[1] = cfg.target_address;
                plan.bytes[2] = cfg.source_address;
                pos           = IDX_W'(3);
            end
            if (len_byte) begin
                plan.bytes[pos] = len;
                pos             = pos + IDX_W'(1);
            end
            plan.bytes[pos] = in_item.sid;
            if (in_item.payload_length == 8'd0) begin
                // Empty payload: service id closes the frame
                plan.last_idx = pos;
                plan.last_end = 1'b1;
                rem_next      = 8'd0;
            end else begin
                plan.bytes[pos + IDX_W'(1)] = in_item.data_byte;
                plan.last_idx = pos + IDX_W'(1);
                plan.last_end = (in_item.payload_length == 8'd1);
                rem_next      = in_item.payload_length - 8'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/kwp_byte_seq.sv */
// ----------------------------------------------------------------------------
// kwp_byte_seq
// Holds a request and steps through its frame bytes one a cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module kwp_byte_seq
    import kwp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire plan_t      plan,
    input  wire logic [7:0] rem_next,
    output logic [7:0]      rem,
    input  wire logic       out_ready,
    output logic            push,
    output out_item_t       push_item
);

    plan_t            plan_reg;
    logic             plan_valid_reg;
    logic             plan_valid_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [7:0]       rem_reg;
    logic [7:0]       rem_reg_next;
    logic             last;
    logic             accept;

    // Push a byte whenever the output stage has room
    assign push    = plan_valid_reg && out_ready;
    assign last    = (idx_reg == plan_reg.last_idx);
    assign s_ready = !plan_valid_reg || (push && last);
    assign accept  = s_valid && s_ready;

    assign push_item.frame_byte = plan_reg.bytes[idx_reg];
    assign push_item.frame_end  = last && plan_reg.last_end;
    assign rem                  = rem_reg;

    // Load a new request or advance through the current one
    always_comb begin
        plan_valid_next = plan_valid_reg;
        idx_next        = idx_reg;
        rem_reg_next    = rem_reg;
        if (accept) begin
            plan_valid_next = 1'b1;
            idx_next        = '0;
            rem_reg_next    = rem_next;
        end else if (push) begin
            if (last) begin
                plan_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plan_valid_reg <= 1'b0;
            idx_reg        <= '0;
            rem_reg        <= 8'd0;
        end else begin
            plan_valid_reg <= plan_valid_next;
            idx_reg        <= idx_next;
            rem_reg        <= rem_reg_next;
        end
    end

    // Capture the byte list with the request
    always_ff @(posedge aclk) begin
        if (accept) begin
            plan_reg <= plan;
        end
    end

endmodule

`default_nettype wire

/* sv/kwp_out_stage.sv */
// ----------------------------------------------------------------------------
// kwp_out_stage
// Output register of the result channel; holds a byte while the sink stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module kwp_out_stage
    import kwp_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire out_item_t push_item,
    output logic           in_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    assign in_ready = !valid_reg || m_ready;

    // Hold while stalled, refill or drain otherwise
    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && push) begin
            data_reg <= push_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

`default_nettype wire

/* sv/kwp2000_header_framer.sv */
// ----------------------------------------------------------------------------
// kwp2000_header_framer
// KWP2000 request framer: turns requests into the header and data byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one request per transfer. The first request of a message
//   carries sid, payload_length and the first data_byte; later ones
//   carry one data_byte each. m_ channel: one frame byte per transfer,
//   frame_end marks the last byte of the frame.
//   cfg_ channel: register writes (format base, target, source, key byte two),
//   always ready; write only while no request is in flight.
//   A request's first byte passes the sequencer and output registers to m_.
//   Throughput, while m_ready stays high: data-only requests are taken back
//   to back, one per cycle; a first request yields 2 to 6 bytes, one a cycle
//   from the sequencer, and holds s_ready low until its last byte is pushed.
//   Reset: registers go to their defaults, no message is open, outputs empty.
//   Stall: when m_ready is low the output register holds its byte; the
//   sequencer then holds its request; s_ready drops after at most one more.
// ----------------------------------------------------------------------------
`default_nettype none

module kwp2000_header_framer
    import kwp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire in_item_t   s_data,
    output logic            m_valid,
    input  wire logic       m_ready,
    output out_item_t       m_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    cfg_t       cfg;
    plan_t      plan;
    logic [7:0] rem;
    logic [7:0] rem_next;
    logic       out_ready;
    logic       push;
    out_item_t  push_item;

    kwp_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kwp_hdr_plan u_plan (
        .in_item  (s_data),
        .cfg      (cfg),
        .rem      (rem),
        .plan     (plan),
        .rem_next (rem_next)
    );

    kwp_byte_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .plan      (plan),
        .rem_next  (rem_next),
        .rem       (rem),
        .out_ready (out_ready),
        .push      (push),
        .push_item (push_item)
    );

    kwp_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .in_ready  (out_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

/* sv/kwp_port_checker.sv */
// ----------------------------------------------------------------------------
// kwp_port_checker
// Port-level checks of the framer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "kwp2000_header_framer_assert.svh"

module kwp_port_checker
    import kwp_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire out_item_t m_data
);

    // Stalled result holds
    `KWP_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

    // Input back-pressure only while a byte is on its way out
    `KWP_ASSERT_NEXT(a_stall_has_output, !s_ready, m_valid)

    // A new result comes from a request via the sequencer or from a header drain
    `KWP_ASSERT_SAME(a_rise_has_source, $rose(m_valid),
                     $past(!s_ready) || $past(s_valid && s_ready, 2))

endmodule

bind kwp2000_header_framer kwp_port_checker u_port_checker (.*);

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the KWP2000 request header framer: drives requests
// and register writes, predicts every frame byte and compares it on m_.
// ----------------------------------------------------------------------------
module tb
    import kwp_pkg::*;
;

    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 480;

    // Predicts the frame bytes of each request and holds them until they arrive
    class frame_scoreboard;
        cfg_t       regs;
        logic [7:0] bytes_left;
        out_item_t  pending[$];
        int         errors;
        int         requests;
        int         bytes_checked;

        function new();
            regs.format_base    = RST_FORMAT_BASE;
            regs.target_address = RST_TARGET_ADDRESS;
            regs.source_address = RST_SOURCE_ADDRESS;
            regs.key_byte_two   = RST_KEY_BYTE_TWO;
            bytes_left    = 8'd0;
            errors        = 0;
            requests      = 0;
            bytes_checked = 0;
        endfunction

        function void set_reg(logic [7:0] idx, logic [7:0] val);
            case (idx)
                CFG_IDX_FORMAT_BASE:    regs.format_base    = val;
                CFG_IDX_TARGET_ADDRESS: regs.target_address = val;
                CFG_IDX_SOURCE_ADDRESS: regs.source_address = val;
                CFG_IDX_KEY_BYTE_TWO:   regs.key_byte_two   = val;
                default: ;
            endcase
        endfunction

        function void push_byte(logic [7:0] b, logic last);
            out_item_t item;
            item.frame_byte = b;
            item.frame_end  = last;
            pending.push_back(item);
        endfunction

        // Expand one accepted request into its expected frame bytes
        function void note_request(in_item_t req);
            logic       with_addr;
            logic       with_len;
            logic [7:0] frame_len;
            logic [7:0] fmt;
            requests++;
            // Pass a payload byte through while a message is open
            if (bytes_left != 8'd0) begin
                bytes_left = bytes_left - 8'd1;
                push_byte(req.data_byte, bytes_left == 8'd0);
                return;
            end
            frame_len = req.payload_length + 8'd1;
            if (req.sid == SID_START_COMM) begin
                with_addr = 1'b1;
                with_len  = 1'b0;
            end else begin
                with_addr = regs.key_byte_two[KEY_ADDR_BIT];
                with_len  = !regs.key_byte_two[KEY_LEN_BIT] ||
                            (req.payload_length > MAX_LEN_IN_FMT);
            end
            fmt = regs.format_base;
            if (!with_len) begin
                fmt = fmt | {2'b00, frame_len[5:0] & FMT_LEN_MASK};
            end
            push_byte(fmt, 1'b0);
            if (with_addr) begin
                push_byte(regs.target_address, 1'b0);
                push_byte(regs.source_address, 1'b0);
            end
            if (with_len) begin
                push_byte(frame_len, 1'b0);
            end
            // Close on the service id for an empty payload
            if (req.payload_length == 8'd0) begin
                push_byte(req.sid, 1'b1);
                bytes_left = 8'd0;
            end else begin
                push_byte(req.sid, 1'b0);
                bytes_left = req.payload_length - 8'd1;
                push_byte(req.data_byte, bytes_left == 8'd0);
            end
        endfunction

        function void check_byte(out_item_t got);
            out_item_t want;
            bytes_checked++;
            if (pending.size() == 0) begin
                $error("unexpected frame byte %02h (frame_end %0b)",
                       got.frame_byte, got.frame_end);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.frame_byte !== want.frame_byte) begin
                $error("frame_byte mismatch: expected %02h, actual %02h",
                       want.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end mismatch: expected %0b, actual %0b",
                       want.frame_end, got.frame_end);
                errors++;
            end
        endfunction

        function void check_leftover();
            if (pending.size() != 0) begin
                $error("%0d frame bytes never arrived", pending.size());
                errors++;
            end
        endfunction
    endclass

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'd0;
    logic [7:0] cfg_data  = 8'd0;

    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;
    int   settings_count = 0;
    int   random_items   = 0;

    frame_scoreboard sb = new();

    kwp2000_header_framer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hand one request to the block, optionally after an idle gap
    task automatic send_request(input in_item_t req);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    // Send a whole message; later requests carry noise in the ignored fields
    task automatic send_message(input logic [7:0] sid, input logic [7:0] plen,
                                input logic [7:0] first_data, input logic counted);
        in_item_t req;
        int       k;
        req.sid            = sid;
        req.payload_length = plen;
        req.data_byte      = first_data;
        send_request(req);
        for (k = 1; k < int'(plen); k++) begin
            req.sid            = 8'($urandom);
            req.payload_length = 8'($urandom);
            req.data_byte      = 8'($urandom);
            send_request(req);
        end
        if (counted) begin
            random_items += (plen == 8'd0) ? 1 : int'(plen);
        end
    endtask

    // Drop valid and wait until every expected byte is out
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers back to back
    task automatic program_regs(input cfg_t c);
        logic [7:0] idx [4];
        logic [7:0] val [4];
        int         i;
        idx[0] = CFG_IDX_FORMAT_BASE;    val[0] = c.format_base;
        idx[1] = CFG_IDX_TARGET_ADDRESS; val[1] = c.target_address;
        idx[2] = CFG_IDX_SOURCE_ADDRESS; val[2] = c.source_address;
        idx[3] = CFG_IDX_KEY_BYTE_TWO;   val[3] = c.key_byte_two;
        cfg_valid <= 1'b1;
        for (i = 0; i < 4; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do @(posedge aclk); while (!cfg_ready);
            sb.set_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    function automatic cfg_t draw_settings(int phase);
        cfg_t c;
        int   pick;
        pick = $urandom_range(0, 2);
        c.format_base = (pick == 0) ? 8'h80 : (pick == 1) ? 8'hC0 : 8'($urandom);
        c.target_address = 8'($urandom);
        c.source_address = ($urandom_range(0, 1) == 0) ? 8'hF1 : 8'($urandom);
        pick = $urandom_range(0, 4);
        case (pick)
            0: c.key_byte_two = 8'h00;
            1: c.key_byte_two = 8'h01;
            2: c.key_byte_two = 8'h08;
            3: c.key_byte_two = 8'h09;
            default: c.key_byte_two = 8'($urandom);
        endcase
        // Allow the length in the format byte for boundary phases 1 and 2
        if (phase == 1 || phase == 2) begin
            c.key_byte_two[KEY_LEN_BIT] = 1'b1;
        end
        return c;
    endfunction

    function automatic logic [7:0] draw_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 8'd0;
        if (r < 85) return 8'($urandom_range(1, 6));
        if (r < 97) return 8'($urandom_range(7, 40));
        return 8'($urandom_range(60, 65));
    endfunction

    function automatic logic [7:0] draw_service();
        if ($urandom_range(0, 4) == 0) return SID_START_COMM;
        return 8'($urandom);
    endfunction

    // Accept frame bytes with random stalls and check each one
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_idle_on ? $urandom_range(0, 12) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_byte(m_data);
        end
    end

    // Main sequence: reset, directed frames, then random phases
    initial begin
        int   phase;
        int   msgs;
        int   m;
        cfg_t c;
        logic [7:0] plen;
        logic [7:0] boundary [3];
        boundary[0] = 8'd62;
        boundary[1] = 8'd63;
        boundary[2] = 8'd255;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: separate length byte, no addresses
        send_message(SID_START_COMM, 8'd0, 8'hA5, 1'b0);
        send_message(8'h00, 8'd0, 8'hFF, 1'b0);
        send_message(8'hFF, 8'd1, 8'h00, 1'b0);
        send_message(SID_START_COMM, 8'd2, 8'hFF, 1'b0);
        drain();

        // All-ones but source: addresses on, length in format byte
        program_regs('{8'hFF, 8'hFF, 8'h00, 8'hFF});
        send_message(8'h10, 8'd0, 8'h3C, 1'b0);
        send_message(SID_START_COMM, 8'd1, 8'h5A, 1'b0);
        send_message(8'h7E, 8'd3, 8'h01, 1'b0);
        drain();

        // All-zero base and target, length in format byte only
        program_regs('{8'h00, 8'h00, 8'hFF, 8'h01});
        send_message(8'h22, 8'd2, 8'h80, 1'b0);
        send_message(SID_START_COMM, 8'd0, 8'hFE, 1'b0);
        drain();

        // Functional target with address info and separate length byte
        program_regs('{8'hC0, 8'h33, 8'hF1, 8'h08});
        send_message(8'h3E, 8'd1, 8'h7F, 1'b0);
        send_message(SID_START_COMM, 8'd0, 8'h01, 1'b0);
        drain();

        // Random phases; the first three each open with a boundary length
        phase = 1;
        while (random_items < RANDOM_ITEMS) begin
            c = draw_settings(phase);
            program_regs(c);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            msgs = $urandom_range(4, 12);
            for (m = 0; m < msgs; m++) begin
                if (m == 0 && phase <= 3) begin
                    send_message(8'($urandom_range(0, 127)), boundary[phase-1],
                                 8'($urandom), 1'b1);
                end else begin
                    plen = draw_length();
                    send_message(draw_service(), plen, 8'($urandom), 1'b1);
                end
            end
            drain();
            phase++;
        end

        sb.check_leftover();
        $display("tb: %0d requests in %0d register settings, %0d frame bytes checked",
                 sb.requests, settings_count + 1, sb.bytes_checked);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Abort a hung run
    initial begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
